### hdl/esc_pkg.sv
// constants and month-length lookup for the epoch seconds to calendar converter
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

   // widths of the working values
   localparam int DividendWidth = 33;
   localparam int OffsetWidth   = 17;
   localparam int UnitWidth     = 33;

   // time constants, in seconds
   localparam logic [UnitWidth-1:0] SecsPerMinute   = 33'd60;
   localparam logic [UnitWidth-1:0] SecsPerHour     = 33'd3600;
   localparam logic [UnitWidth-1:0] SecsPerDay      = 33'd86400;
   localparam logic [UnitWidth-1:0] SecsPerYear     = 33'd31536000;
   localparam logic [UnitWidth-1:0] SecsPerLeapYear = 33'd31622400;
   localparam logic [UnitWidth-1:0] SecsPerMonth28  = 33'd2419200;
   localparam logic [UnitWidth-1:0] SecsPerMonth29  = 33'd2505600;
   localparam logic [UnitWidth-1:0] SecsPerMonth30  = 33'd2592000;
   localparam logic [UnitWidth-1:0] SecsPerMonth31  = 33'd2678400;

   // calendar constants
   localparam logic [11:0] EpochYear       = 12'd1970;
   localparam logic [1:0]  EpochYearMod4   = 2'd2;
   localparam logic [6:0]  EpochYearMod100 = 7'd70;
   localparam logic [8:0]  EpochYearMod400 = 9'd370;
   localparam logic [6:0]  LastMod100      = 7'd99;
   localparam logic [8:0]  LastMod400      = 9'd399;
   localparam logic [3:0]  MonthFeb        = 4'd1;
   localparam logic [3:0]  MonthDec        = 4'd11;

   // reset time-zone offset, UTC+9
   localparam logic signed [OffsetWidth-1:0] ZoneOffsetReset = 17'sd32400;

   typedef logic [3:0] month_index_type;

   // length of a month, zero-based month index
   function automatic logic [4:0] month_days(input month_index_type m, input logic leap);
      logic [4:0] len;
      case (m) inside
         4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
         MonthFeb:                len = leap ? 5'd29 : 5'd28;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

   // length of a month in seconds, zero-based month index
   function automatic logic [UnitWidth-1:0] month_seconds(input month_index_type m,
                                                          input logic leap);
      logic [UnitWidth-1:0] len;
      case (month_days(m, leap))
         5'd28:   len = SecsPerMonth28;
         5'd29:   len = SecsPerMonth29;
         5'd30:   len = SecsPerMonth30;
         default: len = SecsPerMonth31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

### hdl/epoch_seconds_to_calendar_core.sv
// epoch seconds to local gregorian date and time converter, top level
//
// usage:
//   a request carries req_epoch_seconds, seconds since 1970-01-01 00:00:00 UTC,
//   on a valid/ready channel. the zone offset register (csr_write_enable,
//   csr_write_data, signed seconds) is added before conversion; write it only
//   while the block is idle. a shifted time below zero converts as the epoch
//   with rsp_clamped set.
//   one request is worked at a time; req_ready is high only while idle.
//   one shared compare-and-subtract unit peels whole years (up to 136),
//   months (up to 11), days (up to 30), hours (up to 23) and minutes (up to
//   59) off the shifted count, one unit at a time; each stage ends when the
//   next unit no longer fits (months also at december), then the finish state
//   loads the output register and sets rsp_valid. the next request can be
//   taken in the cycle after the load at the earliest.
//   the result sits in an output register; if the receiver stalls with
//   rsp_ready low, the next request is still taken and worked, and waits in
//   its last step until the output register frees up.
//   reset clears the sequencer and rsp_valid and sets the offset to 32400.
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_calendar_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_epoch_seconds,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [11:0]      rsp_year,
   output logic [3:0]       rsp_month,
   output logic [4:0]       rsp_day,
   output logic [4:0]       rsp_hour,
   output logic [5:0]       rsp_minute,
   output logic [5:0]       rsp_second,
   output logic             rsp_clamped,
   input  wire logic        csr_write_enable,
   input  wire logic [esc_pkg::OffsetWidth-1:0] csr_write_data
);
   import esc_pkg::*;

   // sequencer states
   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StYear   = 3'd1;
   localparam logic [2:0] StMonth  = 3'd2;
   localparam logic [2:0] StDay    = 3'd3;
   localparam logic [2:0] StHour   = 3'd4;
   localparam logic [2:0] StMinute = 3'd5;
   localparam logic [2:0] StFinish = 3'd6;

   logic [2:0]                     state_ff, state_in;
   logic signed [OffsetWidth-1:0]  offset_ff;
   logic [UnitWidth-1:0]           secs_ff, secs_in;
   logic [11:0]                    year_ff, year_in;
   logic [1:0]                     mod4_ff, mod4_in;
   logic [6:0]                     mod100_ff, mod100_in;
   logic [8:0]                     mod400_ff, mod400_in;
   month_index_type                month_ff, month_in;
   logic [4:0]                     day_ff, day_in;
   logic [4:0]                     hour_ff, hour_in;
   logic [5:0]                     minute_ff, minute_in;
   logic                           clamp_ff, clamp_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [11:0]                    out_year_ff;
   logic [3:0]                     out_month_ff;
   logic [4:0]                     out_day_ff;
   logic [4:0]                     out_hour_ff;
   logic [5:0]                     out_minute_ff;
   logic [5:0]                     out_second_ff;
   logic                           out_clamped_ff;

   logic [UnitWidth-1:0]           op_b;
   logic [UnitWidth:0]             diff;
   logic                           ge;
   logic                           leap;
   logic signed [DividendWidth:0]  shifted;
   logic                           accept;
   logic                           load_out;

   // leap year by the 400/100/4 rule from running residues
   assign leap = (mod400_ff == 9'd0) || ((mod4_ff == 2'd0) && (mod100_ff != 7'd0));

   // shifted request time
   assign shifted = $signed({2'b00, req_epoch_seconds})
                  + $signed({{(DividendWidth + 1 - OffsetWidth){offset_ff[OffsetWidth-1]}},
                             offset_ff});

   assign accept   = req_valid && req_ready;
   assign load_out = (state_ff == StFinish) && (!rsp_valid_ff || rsp_ready);

   // unit length for the shared subtract and compare unit
   always_comb begin
      case (state_ff)
         StYear: begin
            op_b = leap ? SecsPerLeapYear : SecsPerYear;
         end
         StMonth: begin
            op_b = month_seconds(month_ff, leap);
         end
         StHour: begin
            op_b = SecsPerHour;
         end
         StMinute: begin
            op_b = SecsPerMinute;
         end
         default: begin
            op_b = SecsPerDay;
         end
      endcase
   end

   // shared unit
   assign diff = {1'b0, secs_ff} - {1'b0, op_b};
   assign ge   = !diff[UnitWidth];

   // sequencer next state and datapath
   always_comb begin
      state_in  = state_ff;
      secs_in   = secs_ff;
      year_in   = year_ff;
      mod4_in   = mod4_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      clamp_in  = clamp_ff;
      case (state_ff)
         StIdle: begin
            if (accept) begin
               clamp_in  = shifted[DividendWidth];
               secs_in   = shifted[DividendWidth] ? '0 : shifted[DividendWidth-1:0];
               year_in   = EpochYear;
               mod4_in   = EpochYearMod4;
               mod100_in = EpochYearMod100;
               mod400_in = EpochYearMod400;
               month_in  = '0;
               day_in    = '0;
               hour_in   = '0;
               minute_in = '0;
               state_in  = StYear;
            end
         end
         StYear: begin
            if (ge) begin
               secs_in   = diff[UnitWidth-1:0];
               year_in   = year_ff + 1'b1;
               mod4_in   = mod4_ff + 1'b1;
               mod100_in = (mod100_ff == LastMod100) ? 7'd0 : mod100_ff + 1'b1;
               mod400_in = (mod400_ff == LastMod400) ? 9'd0 : mod400_ff + 1'b1;
            end else begin
               state_in = StMonth;
            end
         end
         StMonth: begin
            if (month_ff != MonthDec && ge) begin
               secs_in  = diff[UnitWidth-1:0];
               month_in = month_ff + 1'b1;
            end else begin
               state_in = StDay;
            end
         end
         StDay: begin
            if (ge) begin
               secs_in = diff[UnitWidth-1:0];
               day_in  = day_ff + 1'b1;
            end else begin
               state_in = StHour;
            end
         end
         StHour: begin
            if (ge) begin
               secs_in = diff[UnitWidth-1:0];
               hour_in = hour_ff + 1'b1;
            end else begin
               state_in = StMinute;
            end
         end
         StMinute: begin
            if (ge) begin
               secs_in   = diff[UnitWidth-1:0];
               minute_in = minute_ff + 1'b1;
            end else begin
               state_in = StFinish;
            end
         end
         StFinish: begin
            if (load_out) begin
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // output handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
         offset_ff    <= ZoneOffsetReset;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            offset_ff <= csr_write_data;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      secs_ff   <= secs_in;
      year_ff   <= year_in;
      mod4_ff   <= mod4_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      clamp_ff  <= clamp_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_year_ff    <= year_ff;
         out_month_ff   <= month_ff + 1'b1;
         out_day_ff     <= day_ff + 1'b1;
         out_hour_ff    <= hour_ff;
         out_minute_ff  <= minute_ff;
         out_second_ff  <= secs_ff[5:0];
         out_clamped_ff <= clamp_ff;
      end
   end

   assign req_ready   = (state_ff == StIdle);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_year    = out_year_ff;
   assign rsp_month   = out_month_ff;
   assign rsp_day     = out_day_ff;
   assign rsp_hour    = out_hour_ff;
   assign rsp_minute  = out_minute_ff;
   assign rsp_second  = out_second_ff;
   assign rsp_clamped = out_clamped_ff;

endmodule

`default_nettype wire

### sim/testbench.sv
// self-checking testbench for the epoch seconds to calendar converter
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned   SecsPerDay      = 86400;
   localparam int unsigned   EpochYear       = 1970;
   localparam int unsigned   FebruaryIndex   = 1;
   localparam int unsigned   DecemberIndex   = 11;
   localparam int unsigned   MonthLength [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   localparam logic [31:0]   EpochMax        = 32'hFFFF_FFFF;
   localparam longint        CycleLimit      = 3_000_000;
   localparam int unsigned   MaxReports      = 50;
   localparam int unsigned   RandomPhaseSize = 325;

   typedef logic signed [esc_pkg::OffsetWidth-1:0] zone_offset_type;

   typedef struct packed {
      logic [31:0] epoch_seconds;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        clamped;
   } calendar_time_type;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic [31:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;
   logic        rsp_clamped;
   logic        csr_write_enable  = 1'b0;
   zone_offset_type csr_write_data = '0;

   // testbench copy of the zone offset register
   zone_offset_type   zone_offset = 17'sd32400;
   calendar_time_type pending_dates[$];
   calendar_time_type oldest_date;
   int unsigned    error_count     = 0;
   longint         cycle_count     = 0;
   int unsigned    hold_off_cycles = 0;
   bit             source_idling   = 1'b1;
   bit             sink_idling     = 1'b1;

   epoch_seconds_to_calendar_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day           (rsp_day),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second),
      .rsp_clamped       (rsp_clamped),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic bit is_leap_year(input int unsigned yr);
      return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
   endfunction

   function automatic int unsigned month_length_of(input int unsigned mon, input int unsigned yr);
      if (mon == FebruaryIndex && is_leap_year(yr)) return 29;
      return MonthLength[mon];
   endfunction

   // gregorian local time for one request under the given offset
   function automatic calendar_time_type convert_epoch(input logic [31:0] secs,
                                                       input zone_offset_type offset);
      calendar_time_type r;
      longint         shifted;
      longint         days;
      longint         rem;
      int unsigned    yr;
      int unsigned    mon;
      r.epoch_seconds = secs;
      shifted = longint'(secs) + longint'(offset);
      r.clamped = (shifted < 0);
      if (shifted < 0) shifted = 0;
      days = shifted / SecsPerDay;
      rem  = shifted % SecsPerDay;
      // whole years, then whole months
      yr = EpochYear;
      while (days >= (is_leap_year(yr) ? 366 : 365)) begin
         days -= is_leap_year(yr) ? 366 : 365;
         yr++;
      end
      mon = 0;
      while (mon < DecemberIndex && days >= month_length_of(mon, yr)) begin
         days -= month_length_of(mon, yr);
         mon++;
      end
      r.year   = 12'(yr);
      r.month  = 4'(mon + 1);
      r.day    = 5'(days + 1);
      r.hour   = 5'(rem / 3600);
      r.minute = 6'((rem % 3600) / 60);
      r.second = 6'(rem % 60);
      return r;
   endfunction

   // days from the epoch to the first of a month
   function automatic longint month_start_day(input int unsigned yr, input int unsigned mon);
      longint days;
      days = 0;
      for (int unsigned y = EpochYear; y < yr; y++) days += is_leap_year(y) ? 366 : 365;
      for (int unsigned m = 0; m < mon; m++) days += month_length_of(m, yr);
      return days;
   endfunction

   // random epoch count, weighted toward the clamp, the top end and local boundaries
   function automatic logic [31:0] random_epoch();
      longint target;
      longint slip;
      slip = longint'($urandom_range(0, 6)) - 3;
      case ($urandom_range(0, 5))
         0, 1: target = $urandom;
         2:    target = $urandom_range(0, 70000);
         3:    target = longint'(EpochMax) - $urandom_range(0, 70000);
         4:    target = longint'($urandom_range(0, 49709)) * SecsPerDay + slip
                        - longint'(zone_offset);
         default: target = month_start_day($urandom_range(EpochYear, 2105),
                                           $urandom_range(0, DecemberIndex)) * SecsPerDay
                           + slip - longint'(zone_offset);
      endcase
      if (target < 0) target = 0;
      if (target > longint'(EpochMax)) target = longint'(EpochMax);
      return target[31:0];
   endfunction

   task automatic report_mismatch(input string detail);
      error_count++;
      if (error_count <= MaxReports) $display("mismatch at cycle %0d: %s", cycle_count, detail);
   endtask

   task automatic check_field(input string name, input logic [11:0] got,
                              input logic [11:0] want, input logic [31:0] secs);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d expected %0d for epoch %0d",
                                   name, got, want, secs));
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dates.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            oldest_date = pending_dates.pop_front();
            check_field("year", rsp_year, oldest_date.year,
                        oldest_date.epoch_seconds);
            check_field("month", 12'(rsp_month), 12'(oldest_date.month),
                        oldest_date.epoch_seconds);
            check_field("day", 12'(rsp_day), 12'(oldest_date.day),
                        oldest_date.epoch_seconds);
            check_field("hour", 12'(rsp_hour), 12'(oldest_date.hour),
                        oldest_date.epoch_seconds);
            check_field("minute", 12'(rsp_minute), 12'(oldest_date.minute),
                        oldest_date.epoch_seconds);
            check_field("second", 12'(rsp_second), 12'(oldest_date.second),
                        oldest_date.epoch_seconds);
            check_field("clamped", 12'(rsp_clamped), 12'(oldest_date.clamped),
                        oldest_date.epoch_seconds);
         end
      end
   end

   // response side ready, with random stalls and one requested long hold-off
   initial begin : response_sink
      int unsigned stall;
      bit          hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0 && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_done = 1'b1;
         end
         if (sink_idling && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 19);
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // offer one request and log its expected date once it is taken
   task automatic send_epoch(input logic [31:0] secs);
      int unsigned gap;
      req_valid         <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (!req_ready);
      pending_dates.push_back(convert_epoch(secs, zone_offset));
      if (source_idling && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
   endtask

   // register writes only with nothing in flight
   task automatic write_zone_offset(input zone_offset_type value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      zone_offset = value;
   endtask

   // offset after reset is utc+9
   task automatic test_reset_offset();
      send_epoch(32'd0);
      send_epoch(EpochMax);
   endtask

   // day, month, year and leap boundaries in utc
   task automatic test_calendar_boundaries();
      logic [31:0] edges [16];
      edges = '{32'd0, 32'd86399, 32'd86400, 32'd31535999, 32'd31536000,
                32'd68255999, 32'd68256000, 32'd946684799, 32'd946684800,
                32'd951782399, 32'd951782400, 32'd951868800, 32'd4107542399,
                32'd4107542400, 32'd4102444799, EpochMax};
      write_zone_offset('0);
      foreach (edges[i]) send_epoch(edges[i]);
   endtask

   // shifted time below zero clamps to the epoch
   task automatic test_clamping();
      write_zone_offset(-17'sd43200);
      send_epoch(32'd0);
      send_epoch(32'd43199);
      send_epoch(32'd43200);
      write_zone_offset(17'sh10000);
      send_epoch(32'd65535);
      send_epoch(32'd65536);
   endtask

   // largest offsets at the top of the input range
   task automatic test_offset_extremes();
      write_zone_offset(17'sd50400);
      send_epoch(EpochMax);
      write_zone_offset(17'sh0FFFF);
      send_epoch(EpochMax);
      send_epoch(32'd0);
   endtask

   // receiver holds off while requests keep coming, so the block stalls its input
   task automatic test_output_backpressure();
      source_idling = 1'b0;
      hold_off_cycles <= 1500;
      repeat (6) send_epoch(random_epoch());
      wait_idle();
      source_idling = 1'b1;
   endtask

   task automatic test_random_traffic(input zone_offset_type offset, input bit idling);
      write_zone_offset(offset);
      source_idling = idling;
      sink_idling   = idling;
      repeat (RandomPhaseSize) send_epoch(random_epoch());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_offset();
      test_calendar_boundaries();
      test_clamping();
      test_offset_extremes();
      test_output_backpressure();
      test_random_traffic('0, 1'b1);
      test_random_traffic(-17'sd43200, 1'b1);
      test_random_traffic(17'sd50400, 1'b1);
      test_random_traffic(zone_offset_type'(int'($urandom_range(0, 93600)) - 43200), 1'b1);
      test_random_traffic(zone_offset_type'($urandom_range(0, 131071)), 1'b1);
      test_random_traffic(17'sd32400, 1'b0);

      wait_idle();
      repeat (300) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/esc_pkg.sv
hdl/epoch_seconds_to_calendar_core.sv
sim/testbench.sv
